FILE: hdl/sha512_pkg.sv
// Package for the SHA-512 engine: round constants, initial hash, command types.
// Used by every module of the engine; depends on nothing.
package sha512_pkg;

  localparam int WORD_W = 64;
  localparam int ROUNDS = 80;

  localparam logic [63:0] PAD_WORD = 64'h8000000000000000;
  localparam logic [63:0] ALL_ONES = 64'hFFFFFFFFFFFFFFFF;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic        load_word;    // write wdata into the schedule slot given by slot
    logic [63:0] wdata;
    logic        init_vars;    // copy hash into working variables
    logic        round;        // run one round
    logic [6:0]  round_idx;
    logic        fold;         // add working variables into hash
    logic        reset_hash;   // restore initial hash
    logic [3:0]  slot;         // schedule slot for load_word
  } dp_cmd_t;

  function automatic logic [63:0] init_hash(input logic [2:0] i);
    logic [63:0] v;
    case (i)
      3'd0: v = 64'h6a09e667f3bcc908;
      3'd1: v = 64'hbb67ae8584caa73b;
      3'd2: v = 64'h3c6ef372fe94f82b;
      3'd3: v = 64'ha54ff53a5f1d36f1;
      3'd4: v = 64'h510e527fade682d1;
      3'd5: v = 64'h9b05688c2b3e6c1f;
      3'd6: v = 64'h1f83d9abfb41bd6b;
      default: v = 64'h5be0cd19137e2179;
    endcase
    return v;
  endfunction

  function automatic logic [63:0] round_k(input logic [6:0] i);
    logic [63:0] v;
    case (i)
      7'd0: v = 64'h428a2f98d728ae22; 7'd1: v = 64'h7137449123ef65cd;
      7'd2: v = 64'hb5c0fbcfec4d3b2f; 7'd3: v = 64'he9b5dba58189dbbc;
      7'd4: v = 64'h3956c25bf348b538; 7'd5: v = 64'h59f111f1b605d019;
      7'd6: v = 64'h923f82a4af194f9b; 7'd7: v = 64'hab1c5ed5da6d8118;
      7'd8: v = 64'hd807aa98a3030242; 7'd9: v = 64'h12835b0145706fbe;
      7'd10: v = 64'h243185be4ee4b28c; 7'd11: v = 64'h550c7dc3d5ffb4e2;
      7'd12: v = 64'h72be5d74f27b896f; 7'd13: v = 64'h80deb1fe3b1696b1;
      7'd14: v = 64'h9bdc06a725c71235; 7'd15: v = 64'hc19bf174cf692694;
      7'd16: v = 64'he49b69c19ef14ad2; 7'd17: v = 64'hefbe4786384f25e3;
      7'd18: v = 64'h0fc19dc68b8cd5b5; 7'd19: v = 64'h240ca1cc77ac9c65;
      7'd20: v = 64'h2de92c6f592b0275; 7'd21: v = 64'h4a7484aa6ea6e483;
      7'd22: v = 64'h5cb0a9dcbd41fbd4; 7'd23: v = 64'h76f988da831153b5;
      7'd24: v = 64'h983e5152ee66dfab; 7'd25: v = 64'ha831c66d2db43210;
      7'd26: v = 64'hb00327c898fb213f; 7'd27: v = 64'hbf597fc7beef0ee4;
      7'd28: v = 64'hc6e00bf33da88fc2; 7'd29: v = 64'hd5a79147930aa725;
      7'd30: v = 64'h06ca6351e003826f; 7'd31: v = 64'h142929670a0e6e70;
      7'd32: v = 64'h27b70a8546d22ffc; 7'd33: v = 64'h2e1b21385c26c926;
      7'd34: v = 64'h4d2c6dfc5ac42aed; 7'd35: v = 64'h53380d139d95b3df;
      7'd36: v = 64'h650a73548baf63de; 7'd37: v = 64'h766a0abb3c77b2a8;
      7'd38: v = 64'h81c2c92e47edaee6; 7'd39: v = 64'h92722c851482353b;
      7'd40: v = 64'ha2bfe8a14cf10364; 7'd41: v = 64'ha81a664bbc423001;
      7'd42: v = 64'hc24b8b70d0f89791; 7'd43: v = 64'hc76c51a30654be30;
      7'd44: v = 64'hd192e819d6ef5218; 7'd45: v = 64'hd69906245565a910;
      7'd46: v = 64'hf40e35855771202a; 7'd47: v = 64'h106aa07032bbd1b8;
      7'd48: v = 64'h19a4c116b8d2d0c8; 7'd49: v = 64'h1e376c085141ab53;
      7'd50: v = 64'h2748774cdf8eeb99; 7'd51: v = 64'h34b0bcb5e19b48a8;
      7'd52: v = 64'h391c0cb3c5c95a63; 7'd53: v = 64'h4ed8aa4ae3418acb;
      7'd54: v = 64'h5b9cca4f7763e373; 7'd55: v = 64'h682e6ff3d6b2b8a3;
      7'd56: v = 64'h748f82ee5defb2fc; 7'd57: v = 64'h78a5636f43172f60;
      7'd58: v = 64'h84c87814a1f0ab72; 7'd59: v = 64'h8cc702081a6439ec;
      7'd60: v = 64'h90befffa23631e28; 7'd61: v = 64'ha4506cebde82bde9;
      7'd62: v = 64'hbef9a3f7b2c67915; 7'd63: v = 64'hc67178f2e372532b;
      7'd64: v = 64'hca273eceea26619c; 7'd65: v = 64'hd186b8c721c0c207;
      7'd66: v = 64'heada7dd6cde0eb1e; 7'd67: v = 64'hf57d4f7fee6ed178;
      7'd68: v = 64'h06f067aa72176fba; 7'd69: v = 64'h0a637dc5a2c898a6;
      7'd70: v = 64'h113f9804bef90dae; 7'd71: v = 64'h1b710b35131c471b;
      7'd72: v = 64'h28db77f523047d84; 7'd73: v = 64'h32caab7b40c72493;
      7'd74: v = 64'h3c9ebe0a15c9bebc; 7'd75: v = 64'h431d67c49c100d4c;
      7'd76: v = 64'h4cc5d4becb3e42b6; 7'd77: v = 64'h597f299cfc657e2a;
      7'd78: v = 64'h5fcb6fab3ad6faec; default: v = 64'h6c44198c4a475817;
    endcase
    return v;
  endfunction

endpackage

FILE: hdl/sha512_if.sv
// Valid/ready channel interfaces for the SHA-512 engine.
// Depends on nothing but the widths of the payload fields.
interface sha512_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] message_word;
  logic [3:0]  valid_bytes;
  logic        last_word;
  modport source (output valid, message_word, valid_bytes, last_word, input ready);
  modport sink (input valid, message_word, valid_bytes, last_word, output ready);
endinterface

interface sha512_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_word;
  logic [2:0]  digest_index;
  logic        digest_last;
  modport source (output valid, digest_word, digest_index, digest_last, input ready);
  modport sink (input valid, digest_word, digest_index, digest_last, output ready);
endinterface

FILE: hdl/sha512_hash_engine_unit.sv
// Top level of the SHA-512 engine: controller plus datapath.
// Depends on sha512_pkg, sha512_if, sha512_ctrl and sha512_dp.
//
//  channel | direction | fields
//  in_     | sink      | message_word[63:0], valid_bytes[3:0], last_word
//  out_    | source    | digest_word[63:0], digest_index[2:0], digest_last
//
// A full word is taken while idle; the sixteenth of a block then starts the
// compression (one round per cycle in the shared round unit, plus load and fold).
// A last word adds the pad words (one a cycle), one or two compressions and
// eight digest words. Reset (rst_n low, synchronous) restores the initial hash.
// A stalled out_ready holds the current digest word; no input is taken meanwhile.
module sha512_hash_engine_unit (
  input  logic        clk,
  input  logic        rst_n,
  sha512_in_if.sink   in_ch,
  sha512_out_if.source out_ch
);

  sha512_pkg::dp_cmd_t cmd;
  logic [2:0]          rd_idx;
  logic [63:0]         hash_rd;

  sha512_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .cmd     (cmd),
    .rd_idx  (rd_idx),
    .hash_rd (hash_rd)
  );

  sha512_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .rd_idx  (rd_idx),
    .hash_rd (hash_rd)
  );

endmodule

FILE: hdl/sha512_dp.sv
// Datapath: hash words, schedule window, working variables, one round per cycle.
// Depends on sha512_pkg.
module sha512_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sha512_pkg::dp_cmd_t  cmd,
  input  logic [2:0]           rd_idx,
  output logic [63:0]          hash_rd
);

  logic [63:0] hash_r [8];
  logic [63:0] win_r [16];
  logic [63:0] var_r [8];

  logic [3:0]  slot;
  logic [63:0] w2, w7, w15, w16, sig0, sig1, w_new, w;
  logic [63:0] big0, big1, pick, vote, t1, t2;

  assign slot = cmd.round_idx[3:0];
  assign w2   = win_r[4'(slot - 4'd2)];
  assign w7   = win_r[4'(slot - 4'd7)];
  assign w15  = win_r[4'(slot - 4'd15)];
  assign w16  = win_r[slot];
  assign sig1 = {w2[18:0], w2[63:19]} ^ {w2[60:0], w2[63:61]} ^ (w2 >> 6);
  assign sig0 = {w15[0], w15[63:1]} ^ {w15[7:0], w15[63:8]} ^ (w15 >> 7);
  assign w_new = sig1 + w7 + sig0 + w16;
  assign w    = (cmd.round_idx < 7'd16) ? w16 : w_new;

  assign big1 = {var_r[4][13:0], var_r[4][63:14]} ^ {var_r[4][17:0], var_r[4][63:18]}
              ^ {var_r[4][40:0], var_r[4][63:41]};
  assign big0 = {var_r[0][27:0], var_r[0][63:28]} ^ {var_r[0][33:0], var_r[0][63:34]}
              ^ {var_r[0][38:0], var_r[0][63:39]};
  assign pick = (var_r[4] & var_r[5]) ^ (~var_r[4] & var_r[6]);
  assign vote = (var_r[0] & var_r[1]) ^ (var_r[0] & var_r[2]) ^ (var_r[1] & var_r[2]);
  assign t1   = var_r[7] + big1 + pick + sha512_pkg::round_k(cmd.round_idx) + w;
  assign t2   = big0 + vote;

  assign hash_rd = hash_r[rd_idx];

  always_ff @(posedge clk) begin
    if (cmd.load_word) begin
      win_r[cmd.slot] <= cmd.wdata;
    end else if (cmd.round) begin
      win_r[slot] <= w;
    end
    if (cmd.init_vars) begin
      for (int i = 0; i < 8; i++) var_r[i] <= hash_r[i];
    end else if (cmd.round) begin
      var_r[7] <= var_r[6];
      var_r[6] <= var_r[5];
      var_r[5] <= var_r[4];
      var_r[4] <= var_r[3] + t1;
      var_r[3] <= var_r[2];
      var_r[2] <= var_r[1];
      var_r[1] <= var_r[0];
      var_r[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.reset_hash) begin
      for (int i = 0; i < 8; i++) hash_r[i] <= sha512_pkg::init_hash(3'(i));
    end else if (cmd.fold) begin
      for (int i = 0; i < 8; i++) hash_r[i] <= hash_r[i] + var_r[i];
    end
  end

endmodule

FILE: hdl/sha512_ctrl.sv
// Controller: word intake, padding sequence, round counter and digest output.
// Depends on sha512_pkg and the channel interfaces.
module sha512_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  sha512_in_if.sink            in_ch,
  sha512_out_if.source         out_ch,
  output sha512_pkg::dp_cmd_t  cmd,
  output logic [2:0]           rd_idx,
  input  logic [63:0]          hash_rd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PAD   = 3'd1;   // write pad / length words
  localparam logic [2:0] S_INIT  = 3'd2;
  localparam logic [2:0] S_ROUND = 3'd3;
  localparam logic [2:0] S_FOLD  = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]  state_r, state_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic [63:0] bytes_r, bytes_nxt;
  logic [6:0]  rnd_r, rnd_nxt;
  logic        fin_r, fin_nxt;      // in padding / final phase
  logic        pend_r, pend_nxt;    // pad byte still owed (full last word)
  logic        done_r, done_nxt;    // length words written, next fold ends message
  logic [2:0]  oidx_r, oidx_nxt;
  logic [3:0]  nb;
  logic [63:0] kept, fmask;
  logic        acc;

  assign acc = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign nb = (in_ch.valid_bytes > 4'd8) ? 4'd8 : in_ch.valid_bytes;
  assign fmask = (nb == 4'd0) ? 64'd0 : (sha512_pkg::ALL_ONES << (7'd64 - {nb, 3'b000}));
  assign kept = (in_ch.message_word & fmask) | (sha512_pkg::PAD_WORD >> {nb, 3'b000});

  assign out_ch.valid        = (state_r == S_OUT);
  assign out_ch.digest_word  = hash_rd;
  assign out_ch.digest_index = oidx_r;
  assign out_ch.digest_last  = (oidx_r == 3'd7);
  assign rd_idx = oidx_r;

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    bytes_nxt = bytes_r;
    rnd_nxt   = rnd_r;
    fin_nxt   = fin_r;
    pend_nxt  = pend_r;
    done_nxt  = done_r;
    oidx_nxt  = oidx_r;
    cmd       = '0;
    cmd.round_idx = rnd_r;
    cmd.slot  = pos_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          cmd.load_word = 1'b1;
          pos_nxt = pos_r + 4'd1;
          if (!in_ch.last_word) begin
            cmd.wdata = in_ch.message_word;
            bytes_nxt = bytes_r + 64'd8;
            if (pos_r == 4'd15) state_nxt = S_INIT;
          end else begin
            bytes_nxt = bytes_r + {60'd0, nb};
            fin_nxt   = 1'b1;
            pend_nxt  = (nb == 4'd8);
            cmd.wdata = (nb == 4'd8) ? in_ch.message_word : kept;
            state_nxt = (pos_r == 4'd15) ? S_INIT : S_PAD;
          end
        end
      end
      S_PAD: begin
        // one schedule word per cycle: owed pad byte, zeros, then length
        cmd.load_word = 1'b1;
        pos_nxt = pos_r + 4'd1;
        if (pend_r) begin
          cmd.wdata = sha512_pkg::PAD_WORD;
          pend_nxt = 1'b0;
          if (pos_r == 4'd15) state_nxt = S_INIT;
        end else if (pos_r == 4'd14) begin
          cmd.wdata = {61'd0, bytes_r[63:61]};
          done_nxt = 1'b1;
        end else if (pos_r == 4'd15) begin
          // low length word, or zero fill when the length has to go into a further block
          cmd.wdata = done_r ? {bytes_r[60:0], 3'b000} : '0;
          state_nxt = S_INIT;
        end else begin
          cmd.wdata = '0;
        end
      end
      S_INIT: begin
        cmd.init_vars = 1'b1;
        rnd_nxt = '0;
        state_nxt = S_ROUND;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        rnd_nxt = rnd_r + 7'd1;
        if (rnd_r == 7'(sha512_pkg::ROUNDS - 1)) state_nxt = S_FOLD;
      end
      S_FOLD: begin
        cmd.fold = 1'b1;
        rnd_nxt = '0;
        if (!fin_r) state_nxt = S_IDLE;
        else if (done_r) begin
          state_nxt = S_OUT;
          oidx_nxt = '0;
        end else begin
          // the length did not fit: a second block of zeros and length
          state_nxt = S_PAD;
        end
      end
      S_OUT: begin
        if (out_ch.ready) begin
          oidx_nxt = oidx_r + 3'd1;
          if (oidx_r == 3'd7) begin
            cmd.reset_hash = 1'b1;
            state_nxt = S_IDLE;
            pos_nxt = '0;
            bytes_nxt = '0;
            fin_nxt = 1'b0;
            done_nxt = 1'b0;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pos_r   <= '0;
      bytes_r <= '0;
      rnd_r   <= '0;
      fin_r   <= 1'b0;
      pend_r  <= 1'b0;
      done_r  <= 1'b0;
      oidx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      bytes_r <= bytes_nxt;
      rnd_r   <= rnd_nxt;
      fin_r   <= fin_nxt;
      pend_r  <= pend_nxt;
      done_r  <= done_nxt;
      oidx_r  <= oidx_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ROUND |-> rnd_r < 7'(sha512_pkg::ROUNDS))
    else $error("round counter out of range");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_ch.ready)
    else $error("input taken while busy");
  a_out_only_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> fin_r && done_r)
    else $error("digest shown before final block");
  a_fold_after_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FOLD |-> $past(state_r) == S_ROUND)
    else $error("fold without rounds");
`endif

endmodule
